// ----- hw/rtl/bba_pkg.sv -----
`default_nettype none

package bba_pkg;

	// field widths of the item payloads
	localparam int unsigned REQ_W = 21;
	localparam int unsigned UNIT_W = 14;
	localparam int unsigned OUT_ORD_W = 4;
	localparam int unsigned USED_W = 21;

	// internal order width and the largest order a request can round to
	localparam int unsigned ORD_W = 5;
	localparam int unsigned MAX_REQ_ORD = 16;

	// block granule and per-block header
	localparam int unsigned UNIT_BYTES = 64;
	localparam int unsigned HEADER_BYTES = 64;

	// opcodes
	localparam logic OPC_ALLOC = 1'b0;
	localparam logic OPC_FREE = 1'b1;

	// result status codes
	localparam logic STAT_DONE = 1'b0;
	localparam logic STAT_REFUSED = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [REQ_W-1:0] request_bytes;
		logic [UNIT_W-1:0] free_unit;
	} in_item_t;

	typedef struct packed {
		logic status;
		logic [UNIT_W-1:0] block_unit;
		logic [OUT_ORD_W-1:0] block_order;
		logic [USED_W-1:0] used_bytes;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_ACHK,
		OP_ULRD,
		OP_ULDO,
		OP_SPLIT,
		OP_SPLIT_LINK,
		OP_SPLIT2,
		OP_GRANT,
		OP_FAIL,
		OP_FRD,
		OP_FCHK,
		OP_MERGE,
		OP_MCHK,
		OP_PH1
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACHK,
		ST_ULRD,
		ST_ULDO,
		ST_SPLIT,
		ST_SPLIT_LINK,
		ST_SPLIT2,
		ST_GRANT,
		ST_FAIL,
		ST_FRD,
		ST_FCHK,
		ST_MERGE,
		ST_MCHK,
		ST_PH1,
		ST_PH2,
		ST_OUT
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic ph2;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_is_free;
		logic op_is_free;
		logic alloc_fail;
		logic range_bad;
		logic not_live;
		logic split_done;
		logic tail_valid;
		logic at_top;
		logic buddy_ok;
		logic head_valid;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bba_ctrl.sv -----
`default_nettype none

module bba_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire bba_pkg::dp_status_t sts,
	output bba_pkg::dp_cmd_t cmd
);

	bba_pkg::state_t state_q;
	bba_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd.op = bba_pkg::OP_NONE;
		cmd.ph2 = 1'b0;
		cmd.out_load = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			bba_pkg::ST_CLEAR: begin
				cmd.op = bba_pkg::OP_CLR;
				if (sts.clr_last) begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			bba_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = bba_pkg::OP_LOAD;
					state_d = sts.in_is_free ? bba_pkg::ST_FRD : bba_pkg::ST_ACHK;
				end
			end
			bba_pkg::ST_ACHK: begin
				if (sts.alloc_fail) begin
					state_d = bba_pkg::ST_FAIL;
				end else begin
					cmd.op = bba_pkg::OP_ACHK;
					state_d = bba_pkg::ST_ULRD;
				end
			end
			bba_pkg::ST_ULRD: begin
				cmd.op = bba_pkg::OP_ULRD;
				state_d = bba_pkg::ST_ULDO;
			end
			bba_pkg::ST_ULDO: begin
				cmd.op = bba_pkg::OP_ULDO;
				state_d = sts.op_is_free ? bba_pkg::ST_MERGE : bba_pkg::ST_SPLIT;
			end
			bba_pkg::ST_SPLIT: begin
				if (sts.split_done) begin
					state_d = bba_pkg::ST_GRANT;
				end else begin
					cmd.op = bba_pkg::OP_SPLIT;
					state_d = bba_pkg::ST_SPLIT_LINK;
				end
			end
			bba_pkg::ST_SPLIT_LINK: begin
				cmd.op = bba_pkg::OP_SPLIT_LINK;
				state_d = sts.tail_valid ? bba_pkg::ST_SPLIT2 : bba_pkg::ST_SPLIT;
			end
			bba_pkg::ST_SPLIT2: begin
				cmd.op = bba_pkg::OP_SPLIT2;
				state_d = bba_pkg::ST_SPLIT;
			end
			bba_pkg::ST_GRANT: begin
				cmd.op = bba_pkg::OP_GRANT;
				state_d = bba_pkg::ST_OUT;
			end
			bba_pkg::ST_FAIL: begin
				cmd.op = bba_pkg::OP_FAIL;
				state_d = bba_pkg::ST_OUT;
			end
			bba_pkg::ST_FRD: begin
				if (sts.range_bad) begin
					state_d = bba_pkg::ST_OUT;
				end else begin
					cmd.op = bba_pkg::OP_FRD;
					state_d = bba_pkg::ST_FCHK;
				end
			end
			bba_pkg::ST_FCHK: begin
				if (sts.not_live) begin
					state_d = bba_pkg::ST_OUT;
				end else begin
					cmd.op = bba_pkg::OP_FCHK;
					state_d = bba_pkg::ST_MERGE;
				end
			end
			bba_pkg::ST_MERGE: begin
				if (sts.at_top) begin
					state_d = bba_pkg::ST_PH1;
				end else begin
					cmd.op = bba_pkg::OP_MERGE;
					state_d = bba_pkg::ST_MCHK;
				end
			end
			bba_pkg::ST_MCHK: begin
				if (sts.buddy_ok) begin
					cmd.op = bba_pkg::OP_MCHK;
					state_d = bba_pkg::ST_ULDO;
				end else begin
					state_d = bba_pkg::ST_PH1;
				end
			end
			bba_pkg::ST_PH1: begin
				cmd.op = bba_pkg::OP_PH1;
				state_d = sts.head_valid ? bba_pkg::ST_PH2 : bba_pkg::ST_OUT;
			end
			bba_pkg::ST_PH2: begin
				cmd.ph2 = 1'b1;
				state_d = bba_pkg::ST_OUT;
			end
			bba_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = bba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bba_dp.sv -----
`default_nettype none

module bba_dp #(
	parameter int unsigned TOP_ORDER = 14
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bba_pkg::in_item_t in_item,
	input wire logic out_ready,
	output logic out_valid,
	output bba_pkg::out_item_t out_item,
	input wire bba_pkg::dp_cmd_t cmd,
	output bba_pkg::dp_status_t sts
);

	localparam int unsigned AW = TOP_ORDER;
	localparam int unsigned NUM_UNITS = 1 << TOP_ORDER;
	localparam int unsigned KW = $clog2(TOP_ORDER + 1);
	localparam int unsigned LW = AW + 1;
	localparam int unsigned MW = KW + 1;
	localparam logic [31:0] TOTAL_BYTES = 32'(bba_pkg::UNIT_BYTES) << TOP_ORDER;
	localparam logic [LW-1:0] NULL_LINK = {1'b1, {AW{1'b0}}};
	localparam int unsigned ORD_W = bba_pkg::ORD_W;

	// block metadata {used, order}, free-list links with a null flag on top
	logic [MW-1:0] meta_mem [NUM_UNITS];
	logic [LW-1:0] next_mem [NUM_UNITS];
	logic [LW-1:0] prev_mem [NUM_UNITS];
	logic [MW-1:0] meta_rd_q;
	logic [LW-1:0] next_rd_q;
	logic [LW-1:0] prev_rd_q;

	logic meta_we, next_we, prev_we;
	logic [AW-1:0] meta_wa, next_wa, prev_wa, meta_ra, link_ra;
	logic [MW-1:0] meta_wd;
	logic [LW-1:0] next_wd, prev_wd;

	// list heads and tails, one per order
	logic [LW-1:0] head_q [TOP_ORDER+1];
	logic [LW-1:0] tail_q [TOP_ORDER+1];

	logic [AW-1:0] clr_q;
	logic [bba_pkg::USED_W-1:0] used_q;
	logic opc_q;
	logic [ORD_W-1:0] o_q;
	logic [bba_pkg::UNIT_W-1:0] fu_q;
	logic [AW-1:0] u_q;
	logic [AW-1:0] t_q;
	logic [KW-1:0] k_q;
	logic res_status_q;
	logic [AW-1:0] res_unit_q;
	logic [KW-1:0] res_order_q;
	logic out_valid_q;
	bba_pkg::out_item_t out_q;

	logic [LW-1:0] head_k, tail_k;
	logic [AW-1:0] k_bit;
	logic [AW-1:0] buddy;
	logic [KW-1:0] j;
	logic found;
	logic [21:0] need;
	logic [ORD_W-1:0] o_in;
	logic [31:0] need_sz;
	logic [31:0] free_b;
	logic [31:0] rel_sz;
	logic [KW-1:0] rd_ord;
	logic rd_used;

	assign head_k = head_q[k_q];
	assign tail_k = tail_q[k_q];
	assign k_bit = AW'(1) << k_q;
	assign buddy = u_q ^ k_bit;
	assign rd_ord = meta_rd_q[KW-1:0];
	assign rd_used = meta_rd_q[KW];

	// round request plus header up to an order
	always_comb begin
		need = 22'(in_item.request_bytes) + 22'(bba_pkg::HEADER_BYTES);
		o_in = ORD_W'(bba_pkg::MAX_REQ_ORD);
		for (int i = bba_pkg::MAX_REQ_ORD; i >= 0; i--) begin
			if ((32'(bba_pkg::UNIT_BYTES) << i) >= 32'(need)) begin
				o_in = ORD_W'(i);
			end
		end
	end

	// smallest order at or above the target with a free block
	always_comb begin
		j = '0;
		found = 1'b0;
		for (int i = TOP_ORDER; i >= 0; i--) begin
			if (!head_q[i][AW] && ORD_W'(i) >= o_q) begin
				j = KW'(i);
				found = 1'b1;
			end
		end
	end

	assign need_sz = 32'(bba_pkg::UNIT_BYTES) << o_q;
	assign free_b = TOTAL_BYTES - 32'(used_q);
	assign rel_sz = 32'(bba_pkg::UNIT_BYTES) << rd_ord;

	// status to the controller
	always_comb begin
		sts.clr_last = (clr_q == {AW{1'b1}});
		sts.in_is_free = (in_item.opcode == bba_pkg::OPC_FREE);
		sts.op_is_free = (opc_q == bba_pkg::OPC_FREE);
		sts.alloc_fail = (o_q > ORD_W'(TOP_ORDER)) || (need_sz > free_b) || !found;
		sts.range_bad = ({1'b0, fu_q} >= (bba_pkg::UNIT_W + 1)'(NUM_UNITS));
		sts.not_live = !rd_used || (ORD_W'(rd_ord) > ORD_W'(TOP_ORDER));
		sts.split_done = (ORD_W'(k_q) == o_q);
		sts.tail_valid = !tail_k[AW];
		sts.at_top = (ORD_W'(k_q) >= ORD_W'(TOP_ORDER));
		sts.buddy_ok = !rd_used && (rd_ord == k_q);
		sts.head_valid = !head_k[AW];
		sts.out_free = !out_valid_q || out_ready;
	end

	// memory port selection per command
	always_comb begin
		meta_we = 1'b0;
		meta_wa = u_q;
		meta_wd = {1'b0, k_q};
		next_we = 1'b0;
		next_wa = u_q;
		next_wd = NULL_LINK;
		prev_we = 1'b0;
		prev_wa = u_q;
		prev_wd = NULL_LINK;
		meta_ra = buddy;
		link_ra = buddy;
		case (cmd.op)
			bba_pkg::OP_CLR: begin
				meta_we = 1'b1;
				meta_wa = clr_q;
				meta_wd = (clr_q == '0) ? {1'b0, KW'(TOP_ORDER)} : '0;
				// unit 0 starts as the only entry of the top list
				next_we = (clr_q == '0);
				next_wa = clr_q;
				prev_we = (clr_q == '0);
				prev_wa = clr_q;
			end
			bba_pkg::OP_ULRD: begin
				link_ra = head_k[AW-1:0];
			end
			bba_pkg::OP_ULDO: begin
				next_we = !prev_rd_q[AW];
				next_wa = prev_rd_q[AW-1:0];
				next_wd = next_rd_q;
				prev_we = !next_rd_q[AW];
				prev_wa = next_rd_q[AW-1:0];
				prev_wd = prev_rd_q;
				if (opc_q == bba_pkg::OPC_FREE) begin
					meta_we = 1'b1;
					meta_wa = u_q & ~k_bit;
					meta_wd = {1'b0, k_q + KW'(1)};
				end
			end
			bba_pkg::OP_SPLIT_LINK: begin
				meta_we = 1'b1;
				next_we = 1'b1;
				prev_we = 1'b1;
				prev_wd = tail_k;
			end
			bba_pkg::OP_SPLIT2: begin
				next_we = 1'b1;
				next_wa = t_q;
				next_wd = {1'b0, u_q};
			end
			bba_pkg::OP_GRANT: begin
				meta_we = 1'b1;
				meta_wd = {1'b1, KW'(o_q)};
			end
			bba_pkg::OP_FRD: begin
				meta_ra = fu_q[AW-1:0];
			end
			bba_pkg::OP_FCHK: begin
				meta_we = 1'b1;
				meta_wd = {1'b0, rd_ord};
			end
			bba_pkg::OP_PH1: begin
				next_we = 1'b1;
				next_wd = head_k;
				prev_we = 1'b1;
			end
			default: begin
			end
		endcase
		if (cmd.ph2) begin
			prev_we = 1'b1;
			prev_wa = t_q;
			prev_wd = {1'b0, u_q};
		end
	end

	// metadata and link memories
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		meta_rd_q <= meta_mem[meta_ra];
		next_rd_q <= next_mem[link_ra];
		prev_rd_q <= prev_mem[link_ra];
	end

	// list heads, tails, byte count, sweep counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= TOP_ORDER; i++) begin
				head_q[i] <= (i == TOP_ORDER) ? '0 : NULL_LINK;
				tail_q[i] <= (i == TOP_ORDER) ? '0 : NULL_LINK;
			end
			used_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == bba_pkg::OP_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.op == bba_pkg::OP_ULDO) begin
				if (prev_rd_q[AW]) begin
					head_q[k_q] <= next_rd_q;
				end
				if (next_rd_q[AW]) begin
					tail_q[k_q] <= prev_rd_q;
				end
			end
			if (cmd.op == bba_pkg::OP_SPLIT_LINK) begin
				if (tail_k[AW]) begin
					head_q[k_q] <= {1'b0, u_q};
				end
				tail_q[k_q] <= {1'b0, u_q};
			end
			if (cmd.op == bba_pkg::OP_PH1) begin
				if (head_k[AW]) begin
					tail_q[k_q] <= {1'b0, u_q};
				end
				head_q[k_q] <= {1'b0, u_q};
			end
			if (cmd.op == bba_pkg::OP_GRANT) begin
				used_q <= used_q + bba_pkg::USED_W'(need_sz);
			end
			if (cmd.op == bba_pkg::OP_FCHK) begin
				used_q <= (32'(used_q) >= rel_sz) ? used_q - bba_pkg::USED_W'(rel_sz) : '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		case (cmd.op)
			bba_pkg::OP_LOAD: begin
				opc_q <= in_item.opcode;
				o_q <= o_in;
				fu_q <= in_item.free_unit;
				res_status_q <= bba_pkg::STAT_DONE;
				res_unit_q <= '0;
				res_order_q <= '0;
			end
			bba_pkg::OP_ACHK: begin
				k_q <= j;
			end
			bba_pkg::OP_ULRD: begin
				u_q <= head_k[AW-1:0];
			end
			bba_pkg::OP_ULDO: begin
				if (opc_q == bba_pkg::OPC_FREE) begin
					u_q <= u_q & ~k_bit;
					k_q <= k_q + KW'(1);
				end
			end
			bba_pkg::OP_SPLIT: begin
				k_q <= k_q - KW'(1);
			end
			bba_pkg::OP_SPLIT_LINK: begin
				t_q <= tail_k[AW-1:0];
				if (tail_k[AW]) begin
					u_q <= u_q + k_bit;
				end
			end
			bba_pkg::OP_SPLIT2: begin
				u_q <= u_q + k_bit;
			end
			bba_pkg::OP_GRANT: begin
				res_unit_q <= u_q;
				res_order_q <= KW'(o_q);
			end
			bba_pkg::OP_FAIL: begin
				res_status_q <= bba_pkg::STAT_REFUSED;
			end
			bba_pkg::OP_FRD: begin
				u_q <= fu_q[AW-1:0];
			end
			bba_pkg::OP_FCHK: begin
				k_q <= rd_ord;
			end
			bba_pkg::OP_PH1: begin
				t_q <= head_k[AW-1:0];
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			out_q.status <= res_status_q;
			out_q.block_unit <= bba_pkg::UNIT_W'(res_unit_q);
			out_q.block_order <= bba_pkg::OUT_ORD_W'(res_order_q);
			out_q.used_bytes <= used_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/buddy_block_allocator.sv -----
// an allocate splits once per order between the free block found and the target order,
// a free merges once per order climbed; a refused allocate or a free of a unit out of
// range skips the split/merge walk over the link memories and goes straight to the result
// one item in flight at a time; a result waits in the output register while the next is taken
// after reset the block clears its unit metadata memory, one entry per cycle,
// through all 2**top_order entries (16384 at the defaults) before the first item is taken
`default_nettype none

module buddy_block_allocator #(
	parameter int unsigned ARENA_BYTES = 1048576,
	parameter int unsigned NUM_ORDERS = 15
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire bba_pkg::in_item_t in_item,
	output logic out_valid,
	input wire logic out_ready,
	output bba_pkg::out_item_t out_item
);

	localparam int unsigned ARENA_UNITS = ARENA_BYTES / bba_pkg::UNIT_BYTES;
	localparam int unsigned LOG_UNITS = $clog2(ARENA_UNITS + 1) - 1;
	localparam int unsigned TOP_ORDER = (LOG_UNITS < NUM_ORDERS - 1) ? LOG_UNITS
		: NUM_ORDERS - 1;

	bba_pkg::dp_cmd_t cmd;
	bba_pkg::dp_status_t sts;

	bba_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	bba_dp #(
		.TOP_ORDER(TOP_ORDER)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_item(out_item),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

`default_nettype wire

// ----- tb/buddy_block_allocator_tb.sv -----
`timescale 1ns / 1ps

module buddy_block_allocator_tb;

	localparam int TOP_ORD = 14;
	localparam int N_UNITS = 1 << TOP_ORD;
	localparam int NO_LINK = -1;
	localparam longint ARENA = 64 << TOP_ORD;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	bba_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	bba_pkg::out_item_t out_item;

	buddy_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// clock and run limit
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#30ms;
		$display("status: fail");
		$finish;
	end

	// shadow allocator state
	bit blk_used [N_UNITS];
	int blk_ord [N_UNITS];
	int link_nx [N_UNITS];
	int link_pv [N_UNITS];
	int free_hd [TOP_ORD+1];
	int free_tl [TOP_ORD+1];
	longint bytes_used;

	bba_pkg::out_item_t grant_q [$];
	int live_units [$];
	int errors;
	bit calm;

	function automatic void shadow_reset();
		for (int u = 0; u < N_UNITS; u++) begin
			blk_used[u] = 1'b0;
			blk_ord[u] = 0;
			link_nx[u] = NO_LINK;
			link_pv[u] = NO_LINK;
		end
		for (int k = 0; k <= TOP_ORD; k++) begin
			free_hd[k] = NO_LINK;
			free_tl[k] = NO_LINK;
		end
		blk_ord[0] = TOP_ORD;
		free_hd[TOP_ORD] = 0;
		free_tl[TOP_ORD] = 0;
		bytes_used = 0;
	endfunction

	function automatic void push_tail(int k, int u);
		link_nx[u] = NO_LINK;
		link_pv[u] = free_tl[k];
		if (free_tl[k] == NO_LINK) begin
			free_hd[k] = u;
		end else begin
			link_nx[free_tl[k]] = u;
		end
		free_tl[k] = u;
	endfunction

	function automatic void push_head(int k, int u);
		link_pv[u] = NO_LINK;
		link_nx[u] = free_hd[k];
		if (free_hd[k] == NO_LINK) begin
			free_tl[k] = u;
		end else begin
			link_pv[free_hd[k]] = u;
		end
		free_hd[k] = u;
	endfunction

	function automatic void unlink(int k, int u);
		int p;
		int n;
		p = link_pv[u];
		n = link_nx[u];
		if (p == NO_LINK) begin
			free_hd[k] = n;
		end else begin
			link_nx[p] = n;
		end
		if (n == NO_LINK) begin
			free_tl[k] = p;
		end else begin
			link_pv[n] = p;
		end
	endfunction

	// expected result of one item, updating the shadow state
	function automatic bba_pkg::out_item_t predict_grant(bba_pkg::in_item_t it);
		bba_pkg::out_item_t r;
		longint need;
		int o;
		int j;
		int u;
		int k;
		int b;
		r = '0;
		r.status = bba_pkg::STAT_DONE;
		if (it.opcode == bba_pkg::OPC_ALLOC) begin
			need = longint'(it.request_bytes) + longint'(bba_pkg::HEADER_BYTES);
			o = 0;
			while (o < 40 && (longint'(64) << o) < need) o++;
			j = o;
			if (o <= TOP_ORD && (longint'(64) << o) <= ARENA - bytes_used) begin
				while (j <= TOP_ORD && free_hd[j] == NO_LINK) j++;
			end else begin
				j = TOP_ORD + 1;
			end
			if (j > TOP_ORD) begin
				r.status = bba_pkg::STAT_REFUSED;
			end else begin
				u = free_hd[j];
				unlink(j, u);
				while (j > o) begin
					j--;
					blk_ord[u] = j;
					push_tail(j, u);
					u += 1 << j;
				end
				blk_ord[u] = o;
				blk_used[u] = 1'b1;
				bytes_used += longint'(64) << o;
				r.block_unit = bba_pkg::UNIT_W'(u);
				r.block_order = bba_pkg::OUT_ORD_W'(o);
				live_units.push_back(u);
			end
		end else begin
			u = int'(it.free_unit);
			if (u < N_UNITS && blk_used[u]) begin
				k = blk_ord[u];
				blk_used[u] = 1'b0;
				bytes_used -= longint'(64) << k;
				foreach (live_units[i]) begin
					if (live_units[i] == u) begin
						live_units.delete(i);
						break;
					end
				end
				// merge upward while the buddy is a free block of equal size
				while (1) begin
					if (k >= TOP_ORD) break;
					b = u ^ (1 << k);
					if (blk_used[b] || blk_ord[b] != k) break;
					unlink(k, b);
					u &= ~(1 << k);
					k++;
					blk_ord[u] = k;
				end
				push_head(k, u);
			end
		end
		r.used_bytes = bytes_used[bba_pkg::USED_W-1:0];
		return r;
	endfunction

	task automatic report(string what, longint want, longint got);
		$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	// send one item and record its expected result once accepted
	task automatic send_item(logic opc, int req, int unit);
		bba_pkg::in_item_t it;
		it.opcode = opc;
		it.request_bytes = bba_pkg::REQ_W'(req);
		it.free_unit = bba_pkg::UNIT_W'(unit);
		if (!calm && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		grant_q.push_back(predict_grant(it));
	endtask

	task automatic alloc(int req);
		send_item(bba_pkg::OPC_ALLOC, req, $urandom_range(N_UNITS - 1));
	endtask

	task automatic release_unit(int unit);
		send_item(bba_pkg::OPC_FREE, $urandom_range(21'h1fffff), unit);
	endtask

	task automatic release_all();
		while (live_units.size() > 0) release_unit(live_units[0]);
	endtask

	// result side: random stalls, check at the edge the item moves
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 15);
		end
	end

	always @(negedge clk) begin
		bba_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (grant_q.size() == 0) begin
				report("unexpected item", 0, 1);
			end else begin
				want = grant_q.pop_front();
				if (out_item.status !== want.status)
					report("status", want.status, out_item.status);
				if (out_item.block_unit !== want.block_unit)
					report("block_unit", want.block_unit, out_item.block_unit);
				if (out_item.block_order !== want.block_order)
					report("block_order", want.block_order, out_item.block_order);
				if (out_item.used_bytes !== want.used_bytes)
					report("used_bytes", want.used_bytes, out_item.used_bytes);
			end
		end
	end

	// sizes, refusals and bad frees
	task automatic test_extremes();
		alloc(int'(ARENA) - int'(bba_pkg::HEADER_BYTES));
		alloc(0);
		release_unit(0);
		release_unit(0);
		alloc(0);
		alloc(int'(ARENA) - int'(bba_pkg::HEADER_BYTES) + 1);
		alloc(int'(ARENA));
		alloc(21'h1fffff);
		alloc(64);
		alloc(1000);
		release_unit(N_UNITS - 1);
		release_unit(1);
		release_unit(14'h2aaa);
		release_unit(14'h1555);
		release_all();
	endtask

	// enough free bytes but no block large enough
	task automatic test_fragmentation();
		int quarter;
		quarter = int'(ARENA / 4) - int'(bba_pkg::HEADER_BYTES);
		repeat (4) alloc(quarter);
		release_unit(0);
		release_unit(N_UNITS / 2);
		alloc(int'(ARENA / 2) - int'(bba_pkg::HEADER_BYTES));
		alloc(quarter);
		release_all();
		alloc(int'(ARENA) - int'(bba_pkg::HEADER_BYTES));
		release_all();
	endtask

	// mostly alloc/free of live blocks with small sizes, some noise
	task automatic test_random(int n);
		int k;
		int sel;
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3 && i < n / 2);
			sel = $urandom_range(99);
			if (sel < 4) begin
				alloc($urandom_range(21'h1fffff));
			end else if (sel < 10) begin
				release_unit($urandom_range(N_UNITS - 1));
			end else if (live_units.size() > 0 &&
					$urandom_range(99) < (live_units.size() > 150 ? 70 : 40)) begin
				release_unit(live_units[$urandom_range(live_units.size() - 1)]);
			end else begin
				k = ($urandom_range(99) < 90) ? $urandom_range(6) : $urandom_range(TOP_ORD);
				alloc($urandom_range((64 << k) - int'(bba_pkg::HEADER_BYTES)));
			end
		end
		calm = 1'b0;
		release_all();
	endtask

	initial begin
		errors = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		shadow_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_fragmentation();
		test_random(1600);
		in_valid <= 1'b0;
		while (grant_q.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
